// File: sv/tdp_pkg.sv
// shared types, codes and constants of the trigger toggled duty pulser
package tdp_pkg;

   // input item and result item
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] left_value;
      logic [7:0] right_value;
   } req_type;

   typedef struct packed {
      logic [7:0] right_out;
      logic       auto_on;
      logic       drive_level;
   } rsp_type;

   // command codes of an item
   localparam logic [2:0] CMD_REPORT    = 3'd0;
   localparam logic [2:0] CMD_TICK      = 3'd1;
   localparam logic [2:0] CMD_FREQ_UP   = 3'd2;
   localparam logic [2:0] CMD_FREQ_DOWN = 3'd3;
   localparam logic [2:0] CMD_DUTY_UP   = 3'd4;
   localparam logic [2:0] CMD_DUTY_DOWN = 3'd5;

   // datapath operations issued by the microcode
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_REPORT    = 4'd1;
   localparam logic [3:0] OP_LOAD_1000 = 4'd2;
   localparam logic [3:0] OP_DIV_STEP  = 4'd3;
   localparam logic [3:0] OP_LOAD_REM  = 4'd4;
   localparam logic [3:0] OP_TICK_DEC  = 4'd5;
   localparam logic [3:0] OP_PHASE     = 4'd6;
   localparam logic [3:0] OP_FREQ_UP   = 4'd7;
   localparam logic [3:0] OP_FREQ_DOWN = 4'd8;
   localparam logic [3:0] OP_DUTY_UP   = 4'd9;
   localparam logic [3:0] OP_DUTY_DOWN = 4'd10;

   // state limits and reset values
   localparam logic [5:0] F2_MIN       = 6'd2;
   localparam logic [5:0] F2_MAX       = 6'd60;
   localparam logic [5:0] F2_RESET     = 6'd24;
   localparam logic [6:0] DUTY_MAX     = 7'd100;
   localparam logic [6:0] DUTY_RESET   = 7'd50;
   localparam logic [7:0] THRESH_RESET = 8'd50;
   localparam logic [7:0] LEVEL_HIGH   = 8'd255;

   // divider numerators
   localparam int unsigned NUM_BITS       = 11;
   localparam logic [10:0] NUM_ENABLE     = 11'd1000;
   localparam logic [10:0] NUM_FULL_CYCLE = 11'd2000;
   localparam logic [10:0] NUM_SCALE      = 11'd20;
   localparam logic [3:0]  DIV_LAST       = 4'(NUM_BITS - 1);

   typedef struct packed {
      logic [3:0] op;
      logic       load_item;
   } ctrl_type;

   typedef struct packed {
      logic enable_edge;
      logic div_busy;
      logic no_switch;
   } status_type;

endpackage

// File: sv/trigger_toggled_duty_pulser.sv
// top level of the trigger toggled duty pulser
//
//   port group    direction  handshake          payload
//   req_          in         req_valid/stall    tdp_pkg::req_type
//   rsp_          out        rsp_valid/stall    tdp_pkg::rsp_type
//   csr_          in         csr_wr_en          press threshold byte
//
// busy time depends on the item: unused code, button, plain report, tick without
// switch, enabling report, or tick that switches or reloads; the divider does
// one of 11 quotient bits per cycle under the microcode step counter.
// the result loads in the last busy cycle; the next item is taken in the cycle after.
// synchronous reset restores the control and pulser state; the threshold returns to 50.
// a waiting result does not block the next item; its last step holds until free.
module trigger_toggled_duty_pulser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tdp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tdp_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   logic [7:0]          thresh_ff, thresh_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tdp_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   tdp_pkg::ctrl_type   ctrl;
   tdp_pkg::status_type status;
   tdp_pkg::rsp_type    result;
   logic                busy;
   logic                done;
   logic                out_free;
   logic                start;

   assign start    = req_valid && !busy;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   tdp_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .start_cmd (req_data.cmd),
      .status    (status),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .busy      (busy),
      .done      (done)
   );

   tdp_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .threshold (thresh_ff),
      .status    (status),
      .result    (result)
   );

   always_comb begin
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= tdp_pkg::THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted item starts the sequencer
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> busy)
      else $error("accepted item did not start the sequencer");

   // a finished item never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   // hold phase only exists with auto mode on
   a_hold_needs_auto: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.drive_level && !rsp_data.auto_on))
      else $error("drive level high while auto mode off");

endmodule

// File: sv/tdp_sequencer.sv
// microcode sequencer: step counter, control store and conditional jumps
module tdp_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            start_cmd,
   input  tdp_pkg::status_type   status,
   input  logic                  out_free,
   output tdp_pkg::ctrl_type     ctrl,
   output logic                  busy,
   output logic                  done
);

   // jump conditions: jump to target when true, else fall through
   localparam logic [2:0] COND_NEXT      = 3'd0;
   localparam logic [2:0] COND_ALWAYS    = 3'd1;
   localparam logic [2:0] COND_NOT_EDGE  = 3'd2;
   localparam logic [2:0] COND_DIV_BUSY  = 3'd3;
   localparam logic [2:0] COND_NO_SWITCH = 3'd4;

   // program addresses
   localparam logic [3:0] STEP_FIN       = 4'd0;
   localparam logic [3:0] STEP_REPORT    = 4'd1;
   localparam logic [3:0] STEP_LOAD_1000 = 4'd2;
   localparam logic [3:0] STEP_DIV       = 4'd3;
   localparam logic [3:0] STEP_LOAD_REM  = 4'd4;
   localparam logic [3:0] STEP_TICK      = 4'd5;
   localparam logic [3:0] STEP_CHECK     = 4'd6;
   localparam logic [3:0] STEP_PHASE     = 4'd7;
   localparam logic [3:0] STEP_FREQ_UP   = 4'd8;
   localparam logic [3:0] STEP_FREQ_DOWN = 4'd9;
   localparam logic [3:0] STEP_DUTY_UP   = 4'd10;
   localparam logic [3:0] STEP_DUTY_DOWN = 4'd11;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] cond;
      logic [3:0] target;
      logic       fin;
   } uword_type;

   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   uword_type  word;
   logic       take;

   // control store
   always_comb begin
      case (step_ff)
         STEP_FIN:       word = '{tdp_pkg::OP_NOP,       COND_NEXT,      STEP_FIN,  1'b1};
         STEP_REPORT:    word = '{tdp_pkg::OP_REPORT,    COND_NOT_EDGE,  STEP_FIN,  1'b0};
         STEP_LOAD_1000: word = '{tdp_pkg::OP_LOAD_1000, COND_NEXT,      STEP_FIN,  1'b0};
         STEP_DIV:       word = '{tdp_pkg::OP_DIV_STEP,  COND_DIV_BUSY,  STEP_DIV,  1'b0};
         STEP_LOAD_REM:  word = '{tdp_pkg::OP_LOAD_REM,  COND_ALWAYS,    STEP_FIN,  1'b0};
         STEP_TICK:      word = '{tdp_pkg::OP_TICK_DEC,  COND_NEXT,      STEP_FIN,  1'b0};
         STEP_CHECK:     word = '{tdp_pkg::OP_NOP,       COND_NO_SWITCH, STEP_FIN,  1'b0};
         STEP_PHASE:     word = '{tdp_pkg::OP_PHASE,     COND_ALWAYS,    STEP_DIV,  1'b0};
         STEP_FREQ_UP:   word = '{tdp_pkg::OP_FREQ_UP,   COND_ALWAYS,    STEP_FIN,  1'b0};
         STEP_FREQ_DOWN: word = '{tdp_pkg::OP_FREQ_DOWN, COND_ALWAYS,    STEP_FIN,  1'b0};
         STEP_DUTY_UP:   word = '{tdp_pkg::OP_DUTY_UP,   COND_ALWAYS,    STEP_FIN,  1'b0};
         STEP_DUTY_DOWN: word = '{tdp_pkg::OP_DUTY_DOWN, COND_ALWAYS,    STEP_FIN,  1'b0};
         default:        word = '{tdp_pkg::OP_NOP,       COND_NEXT,      STEP_FIN,  1'b1};
      endcase
   end

   always_comb begin
      case (word.cond)
         COND_NEXT:      take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_NOT_EDGE:  take = !status.enable_edge;
         COND_DIV_BUSY:  take = status.div_busy;
         COND_NO_SWITCH: take = status.no_switch;
         default:        take = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done    = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            // entry point of each command
            case (start_cmd)
               tdp_pkg::CMD_REPORT:    step_in = STEP_REPORT;
               tdp_pkg::CMD_TICK:      step_in = STEP_TICK;
               tdp_pkg::CMD_FREQ_UP:   step_in = STEP_FREQ_UP;
               tdp_pkg::CMD_FREQ_DOWN: step_in = STEP_FREQ_DOWN;
               tdp_pkg::CMD_DUTY_UP:   step_in = STEP_DUTY_UP;
               tdp_pkg::CMD_DUTY_DOWN: step_in = STEP_DUTY_DOWN;
               default:                step_in = STEP_FIN;
            endcase
         end
      end else if (word.fin) begin
         // hold here until the result register can take the item
         if (out_free) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end else begin
         step_in = take ? word.target : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_FIN;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl.op        = busy_ff ? word.op : tdp_pkg::OP_NOP;
   assign ctrl.load_item = start && !busy_ff;
   assign busy           = busy_ff;

endmodule

// File: sv/tdp_datapath.sv
// datapath: pulser state, item register and shift-subtract divider
module tdp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tdp_pkg::ctrl_type     ctrl,
   input  tdp_pkg::req_type      req_data,
   input  logic [7:0]            threshold,
   output tdp_pkg::status_type   status,
   output tdp_pkg::rsp_type      result
);

   tdp_pkg::req_type item_ff, item_in;
   logic [5:0]  f2_ff, f2_in;
   logic [6:0]  duty_ff, duty_in;
   logic        auto_ff, auto_in;
   logic        hold_ff, hold_in;
   logic        was_ff, was_in;
   logic [9:0]  rem_ff, rem_in;
   logic [7:0]  out_ff, out_in;
   logic [10:0] num_ff, num_in;
   logic [6:0]  part_ff, part_in;
   logic [3:0]  cnt_ff, cnt_in;

   logic        pressed;
   logic [5:0]  divisor;
   logic [7:0]  trial;
   logic [7:0]  diff;
   logic        fits;

   assign pressed = item_ff.left_value > threshold;
   assign divisor = (f2_ff < tdp_pkg::F2_MIN) ? tdp_pkg::F2_MIN : f2_ff;
   assign trial   = {part_ff, num_ff[10]};
   assign diff    = trial - {2'b00, divisor};
   assign fits    = trial >= {2'b00, divisor};

   always_comb begin
      item_in = ctrl.load_item ? req_data : item_ff;
      f2_in   = f2_ff;
      duty_in = duty_ff;
      auto_in = auto_ff;
      hold_in = hold_ff;
      was_in  = was_ff;
      rem_in  = rem_ff;
      out_in  = out_ff;
      num_in  = num_ff;
      part_in = part_ff;
      cnt_in  = cnt_ff;
      case (ctrl.op)
         tdp_pkg::OP_NOP: begin
         end
         tdp_pkg::OP_REPORT: begin
            out_in = item_ff.right_value;
            was_in = pressed;
            if (pressed && !was_ff) begin
               auto_in = !auto_ff;
               // enabling continues in the next steps; disabling clears the hold phase here
               if (auto_ff) begin
                  hold_in = 1'b0;
               end
            end
         end
         tdp_pkg::OP_LOAD_1000: begin
            hold_in = 1'b1;
            out_in  = tdp_pkg::LEVEL_HIGH;
            num_in  = tdp_pkg::NUM_ENABLE;
            part_in = '0;
            cnt_in  = '0;
         end
         tdp_pkg::OP_DIV_STEP: begin
            part_in = fits ? diff[6:0] : trial[6:0];
            num_in  = {num_ff[9:0], fits};
            cnt_in  = cnt_ff + 4'd1;
         end
         tdp_pkg::OP_LOAD_REM: begin
            rem_in = num_ff[9:0];
         end
         tdp_pkg::OP_TICK_DEC: begin
            if (rem_ff != '0) begin
               rem_in = rem_ff - 10'd1;
            end
         end
         tdp_pkg::OP_PHASE: begin
            part_in = '0;
            cnt_in  = '0;
            num_in  = tdp_pkg::NUM_FULL_CYCLE;
            if (hold_ff) begin
               if (duty_ff < tdp_pkg::DUTY_MAX) begin
                  hold_in = 1'b0;
                  out_in  = '0;
                  num_in  = 11'(tdp_pkg::DUTY_MAX - duty_ff) * tdp_pkg::NUM_SCALE;
               end
            end else begin
               if (duty_ff != '0) begin
                  hold_in = 1'b1;
                  out_in  = tdp_pkg::LEVEL_HIGH;
                  num_in  = 11'(duty_ff) * tdp_pkg::NUM_SCALE;
               end
            end
         end
         tdp_pkg::OP_FREQ_UP: begin
            if (f2_ff < tdp_pkg::F2_MAX) begin
               f2_in = f2_ff + 6'd1;
            end
            rem_in = '0;
         end
         tdp_pkg::OP_FREQ_DOWN: begin
            if (f2_ff > tdp_pkg::F2_MIN) begin
               f2_in = f2_ff - 6'd1;
            end
            rem_in = '0;
         end
         tdp_pkg::OP_DUTY_UP: begin
            if (duty_ff < tdp_pkg::DUTY_MAX) begin
               duty_in = duty_ff + 7'd1;
            end
            rem_in = '0;
         end
         tdp_pkg::OP_DUTY_DOWN: begin
            if (duty_ff != '0) begin
               duty_in = duty_ff - 7'd1;
            end
            rem_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_ff   <= tdp_pkg::F2_RESET;
         duty_ff <= tdp_pkg::DUTY_RESET;
         auto_ff <= 1'b0;
         hold_ff <= 1'b0;
         was_ff  <= 1'b0;
         rem_ff  <= '0;
         out_ff  <= '0;
      end else begin
         f2_ff   <= f2_in;
         duty_ff <= duty_in;
         auto_ff <= auto_in;
         hold_ff <= hold_in;
         was_ff  <= was_in;
         rem_ff  <= rem_in;
         out_ff  <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      num_ff  <= num_in;
      part_ff <= part_in;
      cnt_ff  <= cnt_in;
   end

   // enable edge is judged before the report step updates the state
   assign status.enable_edge = pressed && !was_ff && !auto_ff;
   assign status.div_busy    = cnt_ff != tdp_pkg::DIV_LAST;
   assign status.no_switch   = !auto_ff || (rem_ff != '0);

   assign result.right_out   = out_ff;
   assign result.auto_on     = auto_ff;
   assign result.drive_level = hold_ff;

endmodule
